FILE: hw/rtl/swhsr_pkg.sv
// ----------------------------------------------------------------------------
// swhsr_pkg
// Types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int unsigned FrameBits  = 40;
  localparam int unsigned BitsW      = $clog2(FrameBits + 1);
  localparam int unsigned ResultBits = 40;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgStartLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRelease     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstSample = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSecSample   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSettle      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgThreshold   = 3'd5;

  localparam logic [15:0] StartLowRst    = 16'd18000;
  localparam logic [7:0]  ReleaseRst     = 8'd40;
  localparam logic [7:0]  FirstSampleRst = 8'd27;
  localparam logic [7:0]  SecSampleRst   = 8'd67;
  localparam logic [7:0]  SettleRst      = 8'd60;
  localparam logic [7:0]  ThresholdRst   = 8'd24;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhStart   = 4'd1,
    PhRelease = 4'd2,
    PhFirst   = 4'd3,
    PhSecond  = 4'd4,
    PhSettle  = 4'd5,
    PhData    = 4'd6
  } phase_e;

  typedef struct packed {
    logic tick;
    logic line_level;
    logic start_req;
  } in_req_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       bad_response;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
    logic       checksum_ok;
  } out_req_t;

endpackage

FILE: hw/rtl/single_wire_humidity_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Start pulse, response check and 40-bit pulse-width frame decode.
// ----------------------------------------------------------------------------
// Output: the result for a request is registered in the result register, or in the skid while that one is held.
// Throughput: one request per cycle while the skid is empty; state updates in one pass per request.
// A two-entry output stage (result register plus skid) keeps input flowing.
// Reset: asynchronous, active low; idle, config at defaults, frame zero.
module single_wire_humidity_sensor_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  swhsr_pkg::in_req_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output swhsr_pkg::out_req_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [swhsr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [swhsr_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic [15:0] start_low_q;
  logic [7:0]  release_q, first_q, second_q, settle_q, thresh_q;

  swhsr_pkg::phase_e                 phase_q, phase_d;
  logic [15:0]                       timer_q, timer_d;
  logic [7:0]                        pulse_q, pulse_d;
  logic                              last_level_q, last_level_d;
  logic [swhsr_pkg::BitsW-1:0]       bits_q, bits_d, bits_inc;
  logic [swhsr_pkg::FrameBits-1:0]   frame_q, frame_d;
  logic                              low_seen_q, low_seen_d;
  logic [swhsr_pkg::ResultBits-1:0]  result_q, result_d;

  logic        accept;
  logic        done, bad, expired, timed;
  logic [15:0] limit, timer_inc;
  logic [7:0]  sum;
  swhsr_pkg::out_req_t res;

  swhsr_pkg::out_req_t out_q, skid_q;
  logic                out_valid_q, skid_valid_q, out_take;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_take    = out_valid_q & ~out_stall_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= swhsr_pkg::StartLowRst;
      release_q   <= swhsr_pkg::ReleaseRst;
      first_q     <= swhsr_pkg::FirstSampleRst;
      second_q    <= swhsr_pkg::SecSampleRst;
      settle_q    <= swhsr_pkg::SettleRst;
      thresh_q    <= swhsr_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swhsr_pkg::CfgStartLow:    start_low_q <= cfg_wdata_i;
        swhsr_pkg::CfgRelease:     release_q   <= cfg_wdata_i[7:0];
        swhsr_pkg::CfgFirstSample: first_q     <= cfg_wdata_i[7:0];
        swhsr_pkg::CfgSecSample:   second_q    <= cfg_wdata_i[7:0];
        swhsr_pkg::CfgSettle:      settle_q    <= cfg_wdata_i[7:0];
        swhsr_pkg::CfgThreshold:   thresh_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_q)
      swhsr_pkg::PhStart:   limit = start_low_q;
      swhsr_pkg::PhRelease: limit = {8'd0, release_q};
      swhsr_pkg::PhFirst:   limit = {8'd0, first_q};
      swhsr_pkg::PhSecond:  limit = {8'd0, second_q};
      swhsr_pkg::PhSettle:  limit = {8'd0, settle_q};
      default:              limit = 16'd1;
    endcase
  end

  assign timer_inc = timer_q + 16'd1;
  assign expired   = in_data_i.tick & ((timer_inc >= limit) | (timer_inc == 16'd0));
  assign timed     = (phase_q == swhsr_pkg::PhStart)   | (phase_q == swhsr_pkg::PhRelease) |
                     (phase_q == swhsr_pkg::PhFirst)   | (phase_q == swhsr_pkg::PhSecond)  |
                     (phase_q == swhsr_pkg::PhSettle);
  assign bits_inc  = bits_q + 1'b1;

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    pulse_d      = pulse_q;
    last_level_d = last_level_q;
    bits_d       = bits_q;
    frame_d      = frame_q;
    low_seen_d   = low_seen_q;
    result_d     = result_q;
    done         = 1'b0;
    bad          = 1'b0;

    if (timed && in_data_i.tick) begin
      timer_d = expired ? 16'd0 : timer_inc;
    end

    case (phase_q)
      swhsr_pkg::PhIdle: begin
        if (in_data_i.start_req) begin
          phase_d    = swhsr_pkg::PhStart;
          timer_d    = 16'd0;
          bits_d     = '0;
          frame_d    = '0;
          low_seen_d = 1'b0;
          pulse_d    = 8'd0;
        end
      end
      swhsr_pkg::PhStart: begin
        if (expired) phase_d = swhsr_pkg::PhRelease;
      end
      swhsr_pkg::PhRelease: begin
        if (expired) phase_d = swhsr_pkg::PhFirst;
      end
      swhsr_pkg::PhFirst: begin
        if (expired) begin
          low_seen_d = ~in_data_i.line_level;
          phase_d    = swhsr_pkg::PhSecond;
        end
      end
      swhsr_pkg::PhSecond: begin
        if (expired) begin
          if (low_seen_q && in_data_i.line_level) begin
            phase_d = swhsr_pkg::PhSettle;
          end else begin
            bad     = 1'b1;
            phase_d = swhsr_pkg::PhIdle;
          end
        end
      end
      swhsr_pkg::PhSettle: begin
        if (expired) begin
          phase_d      = swhsr_pkg::PhData;
          last_level_d = in_data_i.line_level;
          pulse_d      = 8'd0;
        end
      end
      swhsr_pkg::PhData: begin
        if (in_data_i.line_level) begin
          if (!last_level_q) begin
            pulse_d = (in_data_i.tick) ? 8'd1 : 8'd0;
          end else if (in_data_i.tick && (pulse_q != 8'hFF)) begin
            pulse_d = pulse_q + 8'd1;
          end
        end else if (last_level_q) begin
          frame_d = {frame_q[swhsr_pkg::FrameBits-2:0], (pulse_q > thresh_q)};
          bits_d  = bits_inc;
          if (bits_inc >= swhsr_pkg::BitsW'(swhsr_pkg::FrameBits)) begin
            result_d = swhsr_pkg::ResultBits'(frame_d);
            done     = 1'b1;
            phase_d  = swhsr_pkg::PhIdle;
            bits_d   = '0;
          end
        end
        last_level_d = in_data_i.line_level;
      end
      default: phase_d = swhsr_pkg::PhIdle;
    endcase
  end

  assign sum = result_d[39:32] + result_d[31:24] + result_d[23:16] + result_d[15:8];

  always_comb begin
    res.drive_low     = (phase_d == swhsr_pkg::PhStart);
    res.busy_res      = (phase_d != swhsr_pkg::PhIdle);
    res.done_res      = done;
    res.bad_response  = bad;
    res.humidity_int  = result_d[39:32];
    res.humidity_frac = result_d[31:24];
    res.temp_int      = result_d[23:16];
    res.temp_frac     = result_d[15:8];
    res.checksum_ok   = (sum == result_d[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= swhsr_pkg::PhIdle;
      timer_q      <= 16'd0;
      pulse_q      <= 8'd0;
      last_level_q <= 1'b1;
      bits_q       <= '0;
      frame_q      <= '0;
      low_seen_q   <= 1'b0;
      result_q     <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      pulse_q      <= pulse_d;
      last_level_q <= last_level_d;
      bits_q       <= bits_d;
      frame_q      <= frame_d;
      low_seen_q   <= low_seen_d;
      result_q     <= result_d;
    end
  end

  // output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

FILE: hw/rtl/swhsr_checker.sv
// ----------------------------------------------------------------------------
// swhsr_port_checker
// Port-level checks for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
module swhsr_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input swhsr_pkg::out_req_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_done_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.done_res && out_data_o.bad_response))
    else $error("done and bad response together");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_low |-> out_data_o.busy_res)
    else $error("line driven while not busy");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.done_res || out_data_o.bad_response)
    |-> !out_data_o.busy_res)
    else $error("busy after end of reading");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind single_wire_humidity_sensor_reader swhsr_port_checker u_swhsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/swhsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swhsr_checker
// Watches the request, result and register ports of the sensor reader, runs
// its own model of the start pulse, response check and pulse-width decode
// on every accepted request, and compares each accepted result field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module swhsr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  swhsr_pkg::in_req_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  swhsr_pkg::out_req_t            out_data_i,
  input  logic                           cfg_we_i,
  input  logic [swhsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swhsr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                             fails_o,
  output int                             pending_o,
  output logic                           idle_o,
  output int                             frames_o,
  output int                             rejects_o
);

  logic [15:0] start_lo;
  logic [7:0]  rel_us, first_us, sec_us, settle_us, thr_us;

  swhsr_pkg::phase_e                ph;
  logic [15:0]                      tmr;
  logic [7:0]                       pw;
  logic                             last_lvl;
  logic [swhsr_pkg::BitsW-1:0]      nbits;
  logic [swhsr_pkg::ResultBits-1:0] shreg;
  logic [swhsr_pkg::ResultBits-1:0] frame;
  logic                             low_seen;

  swhsr_pkg::out_req_t pending_readouts[$];
  swhsr_pkg::out_req_t want;

  assign idle_o = (ph == swhsr_pkg::PhIdle);

  // counts ticks of the current phase; true on the tick that ends it
  function automatic logic phase_over(input logic tk, input logic [15:0] lim);
    logic [15:0] nxt;
    if (!tk) return 1'b0;
    nxt = tmr + 16'd1;
    if (nxt >= lim || nxt == 16'd0) begin
      tmr = '0;
      return 1'b1;
    end
    tmr = nxt;
    return 1'b0;
  endfunction

  task automatic advance_reader(input swhsr_pkg::in_req_t r, output swhsr_pkg::out_req_t o);
    logic [7:0] b0, b1, b2, b3, b4, sum;
    o = '0;
    case (ph)
      swhsr_pkg::PhIdle: begin
        if (r.start_req) begin
          ph       = swhsr_pkg::PhStart;
          tmr      = '0;
          nbits    = '0;
          shreg    = '0;
          low_seen = 1'b0;
          pw       = '0;
        end
      end
      swhsr_pkg::PhStart: if (phase_over(r.tick, start_lo)) ph = swhsr_pkg::PhRelease;
      swhsr_pkg::PhRelease: begin
        if (phase_over(r.tick, {8'd0, rel_us})) ph = swhsr_pkg::PhFirst;
      end
      swhsr_pkg::PhFirst: begin
        if (phase_over(r.tick, {8'd0, first_us})) begin
          low_seen = !r.line_level;
          ph       = swhsr_pkg::PhSecond;
        end
      end
      swhsr_pkg::PhSecond: begin
        if (phase_over(r.tick, {8'd0, sec_us})) begin
          if (low_seen && r.line_level) begin
            ph = swhsr_pkg::PhSettle;
          end else begin
            o.bad_response = 1'b1;
            ph             = swhsr_pkg::PhIdle;
          end
        end
      end
      swhsr_pkg::PhSettle: begin
        if (phase_over(r.tick, {8'd0, settle_us})) begin
          ph       = swhsr_pkg::PhData;
          last_lvl = r.line_level;
          pw       = '0;
        end
      end
      swhsr_pkg::PhData: begin
        if (r.line_level) begin
          if (!last_lvl) pw = '0;
          if (r.tick && pw != 8'hFF) pw = pw + 8'd1;
        end else if (last_lvl) begin
          shreg = {shreg[swhsr_pkg::ResultBits-2:0], pw > thr_us};
          nbits = nbits + 1'b1;
          if (nbits >= swhsr_pkg::BitsW'(swhsr_pkg::FrameBits)) begin
            frame      = shreg;
            o.done_res = 1'b1;
            ph         = swhsr_pkg::PhIdle;
            nbits      = '0;
          end
        end
        last_lvl = r.line_level;
      end
      default: ph = swhsr_pkg::PhIdle;
    endcase
    b0  = frame[39:32];
    b1  = frame[31:24];
    b2  = frame[23:16];
    b3  = frame[15:8];
    b4  = frame[7:0];
    sum = b0 + b1 + b2 + b3;
    o.drive_low     = (ph == swhsr_pkg::PhStart);
    o.busy_res      = (ph != swhsr_pkg::PhIdle);
    o.humidity_int  = b0;
    o.humidity_frac = b1;
    o.temp_int      = b2;
    o.temp_frac     = b3;
    o.checksum_ok   = (sum == b4);
  endtask

  task automatic cmp(input string nm, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v != act_v) begin
      fails_o++;
      $error("%s: expected %0d, got %0d", nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_lo   = swhsr_pkg::StartLowRst;
      rel_us     = swhsr_pkg::ReleaseRst;
      first_us   = swhsr_pkg::FirstSampleRst;
      sec_us     = swhsr_pkg::SecSampleRst;
      settle_us  = swhsr_pkg::SettleRst;
      thr_us     = swhsr_pkg::ThresholdRst;
      ph         = swhsr_pkg::PhIdle;
      tmr        = '0;
      pw         = '0;
      last_lvl   = 1'b1;
      nbits      = '0;
      shreg      = '0;
      frame      = '0;
      low_seen   = 1'b0;
      pending_readouts.delete();
      fails_o    = 0;
      pending_o  = 0;
      frames_o   = 0;
      rejects_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_readouts.size() == 0) begin
          fails_o++;
          $error("result accepted with no request outstanding");
        end else begin
          want = pending_readouts.pop_front();
          cmp("drive_low", 8'(want.drive_low), 8'(out_data_i.drive_low));
          cmp("busy_res", 8'(want.busy_res), 8'(out_data_i.busy_res));
          cmp("done_res", 8'(want.done_res), 8'(out_data_i.done_res));
          cmp("bad_response", 8'(want.bad_response), 8'(out_data_i.bad_response));
          cmp("humidity_int", want.humidity_int, out_data_i.humidity_int);
          cmp("humidity_frac", want.humidity_frac, out_data_i.humidity_frac);
          cmp("temp_int", want.temp_int, out_data_i.temp_int);
          cmp("temp_frac", want.temp_frac, out_data_i.temp_frac);
          cmp("checksum_ok", 8'(want.checksum_ok), 8'(out_data_i.checksum_ok));
        end
      end
      // a request at this edge still sees the old register values
      if (in_valid_i && !in_stall_i) begin
        advance_reader(in_data_i, want);
        if (want.done_res) frames_o++;
        if (want.bad_response) rejects_o++;
        pending_readouts.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          swhsr_pkg::CfgStartLow:    start_lo  = cfg_wdata_i;
          swhsr_pkg::CfgRelease:     rel_us    = cfg_wdata_i[7:0];
          swhsr_pkg::CfgFirstSample: first_us  = cfg_wdata_i[7:0];
          swhsr_pkg::CfgSecSample:   sec_us    = cfg_wdata_i[7:0];
          swhsr_pkg::CfgSettle:      settle_us = cfg_wdata_i[7:0];
          swhsr_pkg::CfgThreshold:   thr_us    = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      pending_o = pending_readouts.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the single-wire humidity sensor reader: reset outputs, sensor
// readings at programmed timings, including zero registers, failed
// responses, noisy data lines and a saturating pulse, under random
// backpressure on both sides. Checking is done by swhsr_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QuietLimit = 5000;

  typedef enum int {RdGood, RdNoLow, RdNoHigh, RdNoisy} rd_kind_e;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  swhsr_pkg::in_req_t            in_data;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  swhsr_pkg::out_req_t           out_data;
  logic                          cfg_we;
  logic [swhsr_pkg::CfgIdxW-1:0] cfg_idx;
  logic [swhsr_pkg::CfgDataW-1:0] cfg_wdata;

  int   fails, pending, frames, rejects;
  logic rd_idle;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  int          quiet = 0;
  logic        sat_next = 1'b0;
  logic [15:0] cfg_cur [6];

  single_wire_humidity_sensor_reader u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  swhsr_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fails_o     (fails),
    .pending_o   (pending),
    .idle_o      (rd_idle),
    .frames_o    (frames),
    .rejects_o   (rejects)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [39:0] frame_with_sum(input logic [7:0] h_i, h_f, t_i, t_f);
    logic [7:0] s;
    s = h_i + h_f + t_i + t_f;
    return {h_i, h_f, t_i, t_f, s};
  endfunction

  task automatic push_req(input logic tk, input logic lv, input logic rq);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{tick: tk, line_level: lv, start_req: rq};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_items++;
  endtask

  // n ticked requests, the last one carrying the sampled level
  task automatic timed_wait(input int unsigned n, input logic end_lvl);
    int unsigned k;
    if (n == 0) n = 1;
    for (k = 1; k <= n; k++) begin
      while ($urandom_range(9) == 0) push_req(1'b0, coin(), coin());
      push_req(1'b1, (k == n) ? end_lvl : coin(), coin());
    end
  endtask

  task automatic send_bit(input logic b);
    int unsigned w, k, thr;
    thr = 32'(cfg_cur[swhsr_pkg::CfgThreshold]);
    w = b ? thr + 1 + $urandom_range(2) : $urandom_range(thr);
    // one long pulse runs the width counter into saturation
    if (b && sat_next) begin
      w        = 256;
      sat_next = 1'b0;
    end
    if (w == 0) push_req(1'b0, 1'b1, coin());
    for (k = 0; k < w; k++) begin
      if ($urandom_range(7) == 0) push_req(1'b0, 1'b1, coin());
      push_req(1'b1, 1'b1, coin());
    end
    push_req(coin(), 1'b0, coin());
  endtask

  task automatic do_reading(input rd_kind_e kind, input logic [39:0] bits);
    int i;
    repeat ($urandom_range(2)) push_req(coin(), coin(), 1'b0);
    push_req(coin(), coin(), 1'b1);
    timed_wait(32'(cfg_cur[swhsr_pkg::CfgStartLow]), coin());
    timed_wait(32'(cfg_cur[swhsr_pkg::CfgRelease]), coin());
    timed_wait(32'(cfg_cur[swhsr_pkg::CfgFirstSample]), kind == RdNoLow);
    timed_wait(32'(cfg_cur[swhsr_pkg::CfgSecSample]),
               (kind == RdNoLow) ? coin() : (kind != RdNoHigh));
    if (kind == RdNoLow || kind == RdNoHigh) return;
    timed_wait(32'(cfg_cur[swhsr_pkg::CfgSettle]), 1'b0);
    if (kind == RdNoisy) begin
      while (!rd_idle) push_req(coin(), coin(), coin());
    end else begin
      for (i = 39; i >= 0; i--) send_bit(bits[i]);
    end
  endtask

  // finish any reading in flight and wait for every result
  task automatic settle_block();
    logic lv;
    lv = 1'b1;
    while (!rd_idle) begin
      push_req(1'b1, lv, 1'b0);
      lv = !lv;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_wr(input logic [swhsr_pkg::CfgIdxW-1:0] idx);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (idx == swhsr_pkg::CfgStartLow) ? cfg_cur[idx] : {junk, cfg_cur[idx][7:0]};
    @(negedge clk);
  endtask

  task automatic program_regs();
    settle_block();
    cfg_wr(swhsr_pkg::CfgStartLow);
    cfg_wr(swhsr_pkg::CfgRelease);
    cfg_wr(swhsr_pkg::CfgFirstSample);
    cfg_wr(swhsr_pkg::CfgSecSample);
    cfg_wr(swhsr_pkg::CfgSettle);
    cfg_wr(swhsr_pkg::CfgThreshold);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  task automatic set_regs(input int unsigned sl, rl, fs, ss, st, th);
    cfg_cur[swhsr_pkg::CfgStartLow]    = 16'(sl);
    cfg_cur[swhsr_pkg::CfgRelease]     = 16'(rl);
    cfg_cur[swhsr_pkg::CfgFirstSample] = 16'(fs);
    cfg_cur[swhsr_pkg::CfgSecSample]   = 16'(ss);
    cfg_cur[swhsr_pkg::CfgSettle]      = 16'(st);
    cfg_cur[swhsr_pkg::CfgThreshold]   = 16'(th);
    program_regs();
  endtask

  task automatic randomize_regs();
    set_regs($urandom_range(0, 8), $urandom_range(0, 3), $urandom_range(0, 3),
             $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 2));
  endtask

  task automatic random_run(input int unsigned target);
    int unsigned first_n, pick;
    rd_kind_e    kind;
    logic [39:0] bits;
    first_n = n_items;
    randomize_regs();
    while (n_items - first_n < target) begin
      pick = $urandom_range(99);
      if (pick < 70) kind = RdGood;
      else if (pick < 80) kind = RdNoLow;
      else if (pick < 90) kind = RdNoHigh;
      else kind = RdNoisy;
      bits = {8'($urandom_range(255)), $urandom()};
      if (coin()) bits = frame_with_sum(bits[39:32], bits[31:24], bits[23:16], bits[15:8]);
      do_reading(kind, bits);
      if ($urandom_range(3) == 0) randomize_regs();
      else if ($urandom_range(3) == 0) settle_block();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    cfg_cur[swhsr_pkg::CfgStartLow]    = swhsr_pkg::StartLowRst;
    cfg_cur[swhsr_pkg::CfgRelease]     = {8'd0, swhsr_pkg::ReleaseRst};
    cfg_cur[swhsr_pkg::CfgFirstSample] = {8'd0, swhsr_pkg::FirstSampleRst};
    cfg_cur[swhsr_pkg::CfgSecSample]   = {8'd0, swhsr_pkg::SecSampleRst};
    cfg_cur[swhsr_pkg::CfgSettle]      = {8'd0, swhsr_pkg::SettleRst};
    cfg_cur[swhsr_pkg::CfgThreshold]   = {8'd0, swhsr_pkg::ThresholdRst};
    tx_idle_pct  = 27;
    rx_stall_pct = 61;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // outputs straight after reset: idle, zero frame, checksum good
    repeat (8) push_req(coin(), coin(), 1'b0);

    set_regs(1, 1, 1, 1, 1, 1);
    do_reading(RdNoLow, '0);
    do_reading(RdNoHigh, '0);

    // zero timings end on the first tick
    set_regs(0, 0, 0, 0, 0, 0);
    do_reading(RdNoHigh, '0);
    do_reading(RdNoLow, '0);

    sat_next = 1'b1;
    random_run(100);

    tx_idle_pct  = 61;
    rx_stall_pct = 27;
    random_run(100);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_run(100);

    settle_block();
    repeat (10) @(negedge clk);
    $display("Run covered %0d requests over %0d register settings",
             n_items, n_settings + 1);
    $display("with %0d frames decoded and %0d sensor responses rejected", frames, rejects);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/swhsr_pkg.sv
hw/rtl/single_wire_humidity_sensor_reader.sv
hw/rtl/swhsr_checker.sv
tb/swhsr_checker.sv
tb/tb_top.sv
